FILE: hdl/dshs_pkg.sv
`default_nettype none
package dshs_pkg;

  localparam int unsigned DSHS_QUEUE_DEPTH = 2;

  localparam int unsigned TEMP_W   = 18;
  localparam int unsigned FAULT_W  = 8;
  localparam int unsigned MV_W     = 13;
  localparam int unsigned WEIGHT_W = 11;
  localparam int unsigned LIMIT_W  = 17;
  localparam int unsigned SCORE_W  = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL  = 11'd1024;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT   = 11'd922;
  localparam logic [LIMIT_W-1:0]  RST_DIFF     = 17'd500;
  localparam logic [LIMIT_W-1:0]  RST_JUMP     = 17'd1500;
  localparam logic [MV_W-1:0]     RST_VOLT_LO  = 13'd3130;
  localparam logic [MV_W-1:0]     RST_VOLT_HI  = 13'd3460;
  localparam logic [SCORE_W-1:0]  RST_GREEN    = 7'd90;
  localparam logic [SCORE_W-1:0]  RST_YELLOW   = 7'd60;

  localparam logic [SCORE_W-1:0]  SCORE_FULL   = 7'd100;
  localparam logic [SCORE_W-1:0]  SCORE_NONE   = 7'd0;
  localparam logic [SCORE_W-1:0]  COST_SENSOR  = 7'd40;
  localparam logic [SCORE_W-1:0]  COST_DIFF    = 7'd25;
  localparam logic [SCORE_W-1:0]  COST_JUMP    = 7'd15;
  localparam logic [SCORE_W-1:0]  COST_VOLT    = 7'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_WEIGHT = 3'd0,
    CFG_DIFF_LIMIT    = 3'd1,
    CFG_JUMP_LIMIT    = 3'd2,
    CFG_VOLT_LOW      = 3'd3,
    CFG_VOLT_HIGH     = 3'd4,
    CFG_GREEN_FLOOR   = 3'd5,
    CFG_YELLOW_FLOOR  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    LEVEL_GREEN  = 2'd0,
    LEVEL_YELLOW = 2'd1,
    LEVEL_RED    = 2'd2
  } level_t;

  typedef enum logic [2:0] {
    ADV_NORMAL     = 3'd0,
    ADV_BOTH_DOWN  = 3'd1,
    ADV_PROBE_DOWN = 3'd2,
    ADV_RTD_FAULT  = 3'd3,
    ADV_DIFF       = 3'd4,
    ADV_JUMP       = 3'd5,
    ADV_VOLTAGE    = 3'd6
  } advice_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] filter_weight;
    logic [LIMIT_W-1:0]  diff_limit;
    logic [LIMIT_W-1:0]  jump_limit;
    logic [MV_W-1:0]     volt_low;
    logic [MV_W-1:0]     volt_high;
    logic [SCORE_W-1:0]  green_floor;
    logic [SCORE_W-1:0]  yellow_floor;
  } cfg_t;

  // Classified sample set handed from the front to the back
  typedef struct packed {
    logic                     faulted;
    logic                     online;
    logic                     jump_hit;
    logic                     volt_bad;
    logic signed [TEMP_W-1:0] filtered;
    logic signed [TEMP_W-1:0] probe;
  } rec_t;

endpackage
`default_nettype wire

FILE: hdl/dshs_front.sv
`default_nettype none
module dshs_front
  import dshs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cfg_t                     cfg,
  input  wire logic                     accept,
  input  wire logic signed [TEMP_W-1:0] rtd_temp,
  input  wire logic [FAULT_W-1:0]       rtd_fault,
  input  wire logic                     probe_online,
  input  wire logic signed [TEMP_W-1:0] probe_temp,
  input  wire logic [MV_W-1:0]          supply_mv,
  output rec_t                          rec
);

  logic                     first_r, first_nxt;
  logic signed [TEMP_W-1:0] last_r, last_nxt;

  logic                     faulted;
  logic signed [TEMP_W-1:0] prev;
  logic [WEIGHT_W-1:0]      w_sat;
  logic signed [TEMP_W:0]   delta;
  logic [TEMP_W:0]          delta_mag;
  logic signed [TEMP_W+12:0] prod;
  logic signed [TEMP_W+2:0] step_sum;
  logic signed [TEMP_W-1:0] filtered;

  always_comb begin
    faulted = (rtd_fault != '0);
    prev    = (first_r && !faulted) ? rtd_temp : last_r;
    w_sat   = (cfg.filter_weight > WEIGHT_FULL) ? WEIGHT_FULL : cfg.filter_weight;
    delta   = {rtd_temp[TEMP_W-1], rtd_temp} - {prev[TEMP_W-1], prev};
    delta_mag = delta[TEMP_W] ? (TEMP_W+1)'(-delta) : delta;
    // prev + floor(w * (raw - prev) / 1024) equals the weighted mean, floored
    prod     = $signed({1'b0, w_sat}) * delta;
    step_sum = {{3{prev[TEMP_W-1]}}, prev} + prod[TEMP_W+12:10];
    filtered = faulted ? rtd_temp : step_sum[TEMP_W-1:0];

    rec.faulted  = faulted;
    rec.online   = probe_online;
    rec.jump_hit = !faulted && (delta_mag > {2'b00, cfg.jump_limit});
    rec.volt_bad = (supply_mv < cfg.volt_low) || (supply_mv > cfg.volt_high);
    rec.filtered = filtered;
    rec.probe    = probe_temp;
  end

  always_comb begin
    first_nxt = first_r;
    last_nxt  = last_r;
    if (accept) begin
      first_nxt = 1'b0;
      if (!faulted) begin
        last_nxt = filtered;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      last_r  <= '0;
    end else begin
      first_r <= first_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/dshs_queue.sv
`default_nettype none
module dshs_queue
  import dshs_pkg::*;
#(
  parameter int unsigned DEPTH = DSHS_QUEUE_DEPTH
)(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire rec_t push_rec,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output rec_t      head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rec_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not advance on transfer in");

  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> wr_ptr_r == rd_ptr_r)
    else $error("pointers differ on empty queue");

endmodule
`default_nettype wire

FILE: hdl/dshs_back.sv
`default_nettype none
module dshs_back
  import dshs_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cfg_t                      cfg,
  input  wire logic                      q_valid,
  input  wire rec_t                      q_head,
  output logic                           q_pop,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output logic [SCORE_W-1:0]             out_score,
  output logic [1:0]                     out_level,
  output logic [2:0]                     out_advice,
  output logic signed [TEMP_W-1:0]       out_filtered_temp
);

  logic                     valid_r, valid_nxt;
  logic [SCORE_W-1:0]       score_r;
  level_t                   level_r;
  advice_t                  advice_r;
  logic signed [TEMP_W-1:0] filt_r;

  logic [TEMP_W:0]          diff;
  logic [TEMP_W:0]          diff_mag;
  logic                     diff_hit;
  logic [SCORE_W-1:0]       score;
  advice_t                  advice;
  level_t                   level;

  assign q_pop = q_valid && (!valid_r || out_pop);

  always_comb begin
    diff     = {q_head.filtered[TEMP_W-1], q_head.filtered}
             - {q_head.probe[TEMP_W-1], q_head.probe};
    diff_mag = diff[TEMP_W] ? (TEMP_W+1)'(-diff) : diff;
    diff_hit = q_head.online && !q_head.faulted
            && (diff_mag > {2'b00, cfg.diff_limit});

    score  = SCORE_FULL;
    advice = ADV_NORMAL;
    // Penalties never exceed 70, so the score stays in range without clamping
    if (!q_head.online && q_head.faulted) begin
      score  = SCORE_NONE;
      advice = ADV_BOTH_DOWN;
    end else begin
      if (!q_head.online) begin
        score  = score - COST_SENSOR;
        advice = ADV_PROBE_DOWN;
      end
      if (q_head.faulted) begin
        score  = score - COST_SENSOR;
        advice = ADV_RTD_FAULT;
      end
      if (diff_hit) begin
        score  = score - COST_DIFF;
        advice = ADV_DIFF;
      end
      if (q_head.jump_hit) begin
        score  = score - COST_JUMP;
        advice = ADV_JUMP;
      end
      if (q_head.volt_bad) begin
        score  = score - COST_VOLT;
        advice = ADV_VOLTAGE;
      end
    end

    priority if (score >= cfg.green_floor) begin
      level = LEVEL_GREEN;
    end else if (score >= cfg.yellow_floor) begin
      level = LEVEL_YELLOW;
    end else begin
      level = LEVEL_RED;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      score_r  <= score;
      level_r  <= level;
      advice_r <= advice;
      filt_r   <= q_head.filtered;
    end
  end

  assign out_empty         = !valid_r;
  assign out_score         = score_r;
  assign out_level         = level_r;
  assign out_advice        = advice_r;
  assign out_filtered_temp = filt_r;

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !out_empty)
    else $error("result register not loaded after queue transfer");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |-> !q_pop)
    else $error("result overwritten while stalled");

  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_score <= SCORE_FULL)
    else $error("score out of range");

endmodule
`default_nettype wire

FILE: hdl/dual_sensor_health_scorer.sv
// Health scorer for an RTD plus a digital probe. Each sample set pushed in
// yields one result (score, green/yellow/red level, advice code, smoothed
// RTD temperature) on the output queue side, in order. A sample set is
// taken every cycle while the internal queue has room: the front smooths
// the RTD reading with one 12x19 multiply and updates the filter state in
// the same cycle, so the filter recurrence sets the one-item-per-cycle rate.
// Each result is registered first in the queue and then in the output
// register; a stalled output side fills the QUEUE_DEPTH-entry
// queue before full rises. Configuration writes are always ready and should
// be made only while no results are outstanding.
`default_nettype none
module dual_sensor_health_scorer
  import dshs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DSHS_QUEUE_DEPTH
)(
  input  wire logic                      clk,
  input  wire logic                      rst_n,

  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data,

  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire logic signed [TEMP_W-1:0]  in_rtd_temp,
  input  wire logic [FAULT_W-1:0]        in_rtd_fault,
  input  wire logic                      in_probe_online,
  input  wire logic signed [TEMP_W-1:0]  in_probe_temp,
  input  wire logic [MV_W-1:0]           in_supply_mv,

  output logic                           out_empty,
  input  wire logic                      out_pop,
  output logic [SCORE_W-1:0]             out_score,
  output logic [1:0]                     out_level,
  output logic [2:0]                     out_advice,
  output logic signed [TEMP_W-1:0]       out_filtered_temp
);

  cfg_t cfg_r, cfg_nxt;
  logic in_accept;
  rec_t front_rec;
  logic q_full;
  logic q_valid;
  logic q_pop;
  rec_t q_head;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FILTER_WEIGHT: cfg_nxt.filter_weight = cfg_data[WEIGHT_W-1:0];
        CFG_DIFF_LIMIT:    cfg_nxt.diff_limit    = cfg_data[LIMIT_W-1:0];
        CFG_JUMP_LIMIT:    cfg_nxt.jump_limit    = cfg_data[LIMIT_W-1:0];
        CFG_VOLT_LOW:      cfg_nxt.volt_low      = cfg_data[MV_W-1:0];
        CFG_VOLT_HIGH:     cfg_nxt.volt_high     = cfg_data[MV_W-1:0];
        CFG_GREEN_FLOOR:   cfg_nxt.green_floor   = cfg_data[SCORE_W-1:0];
        CFG_YELLOW_FLOOR:  cfg_nxt.yellow_floor  = cfg_data[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_weight <= RST_WEIGHT;
      cfg_r.diff_limit    <= RST_DIFF;
      cfg_r.jump_limit    <= RST_JUMP;
      cfg_r.volt_low      <= RST_VOLT_LO;
      cfg_r.volt_high     <= RST_VOLT_HI;
      cfg_r.green_floor   <= RST_GREEN;
      cfg_r.yellow_floor  <= RST_YELLOW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dshs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .accept       (in_accept),
    .rtd_temp     (in_rtd_temp),
    .rtd_fault    (in_rtd_fault),
    .probe_online (in_probe_online),
    .probe_temp   (in_probe_temp),
    .supply_mv    (in_supply_mv),
    .rec          (front_rec)
  );

  dshs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept),
    .push_rec (front_rec),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  dshs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_score         (out_score),
    .out_level         (out_level),
    .out_advice        (out_advice),
    .out_filtered_temp (out_filtered_temp)
  );

endmodule
`default_nettype wire
